[design/sha_pkg.sv]
// Shared types, constants and round functions for the SHA-256 hash engine.
// Depends on nothing; used by sha_core, sha256_hash_engine_top and sha_checker.
package sha_pkg;

   typedef logic [31:0] word_type;
   typedef logic [0:7][31:0] hash_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_PAD,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic       shift_byte;
      logic [7:0] byte_value;
      logic       load_vars;
      logic       round_step;
   } core_ctrl_type;

   localparam hash_type IV = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [0:63][31:0] ROUND_K = {
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [7:0] PAD_MARK   = 8'h80;
   localparam logic [5:0] LEN_START  = 6'd56;
   localparam logic [5:0] BLOCK_LAST = 6'd63;
   localparam logic [5:0] ROUND_LAST = 6'd63;
   localparam logic [2:0] WORD_LAST  = 3'd7;

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

[design/sha256_hash_engine_top.sv]
// Top level of the SHA-256 hash engine: byte intake, padding sequencer,
// chaining words and digest output. Uses sha_pkg and sha_core.
//
//   channel | dir | handshake            | payload
//   req     | in  | req_valid/req_stall  | data_byte, byte_valid, end_of_message
//   rsp     | out | rsp_valid/rsp_stall  | digest_word, word_index, last_word
//
// Each 64th byte starts a compression (64 rounds through the single round unit,
// then a fold into the chaining words), during which req_stall is high. An
// end mark adds padding bytes (up to 72), one per cycle outside compressions,
// with one or two compressions, then eight digest words, one per cycle that
// rsp_stall is low. Input is stalled until the last word is taken.
// Synchronous active-high reset; no clearing pass.
module sha256_hash_engine_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   sha_pkg::state_type state_ff, state_in;
   logic [5:0]         count_ff, count_in;
   logic [60:0]        total_ff, total_in;
   logic [5:0]         round_ff, round_in;
   logic [2:0]         word_ff, word_in;
   sha_pkg::hash_type  chain_ff, chain_in;
   logic               mark_done_ff, mark_done_in;
   logic               len_phase_ff, len_phase_in;
   logic               len_done_ff, len_done_in;
   logic               eom_pend_ff, eom_pend_in;

   sha_pkg::core_ctrl_type ctrl;
   sha_pkg::hash_type      vars;

   logic        accept, byte_take, block_full, is_len, out_take, out_done;
   logic [63:0] len_shift;
   logic [7:0]  pad_byte;

   sha_core u_core (
      .clock       (clock),
      .ctrl        (ctrl),
      .round_index (round_ff),
      .chain       (chain_ff),
      .vars        (vars)
   );

   // outputs and controls of the sequencer
   always_comb begin
      accept    = (state_ff == sha_pkg::ST_IDLE) && req_valid;
      byte_take = accept && req_byte_valid;
      out_take  = (state_ff == sha_pkg::ST_OUT) && !rsp_stall;
      out_done  = out_take && (word_ff == sha_pkg::WORD_LAST);

      // length bytes follow once the count reaches 56 after the 0x80 mark
      is_len    = mark_done_ff && (len_phase_ff || (count_ff == sha_pkg::LEN_START));
      len_shift = {total_ff, 3'b000} << {count_ff[2:0], 3'b000};
      if (!mark_done_ff) begin
         pad_byte = sha_pkg::PAD_MARK;
      end else if (is_len) begin
         pad_byte = len_shift[63:56];
      end else begin
         pad_byte = 8'h00;
      end

      ctrl.shift_byte = byte_take || (state_ff == sha_pkg::ST_PAD);
      ctrl.byte_value = (state_ff == sha_pkg::ST_PAD) ? pad_byte : req_data_byte;
      block_full      = ctrl.shift_byte && (count_ff == sha_pkg::BLOCK_LAST);
      ctrl.load_vars  = block_full;
      ctrl.round_step = (state_ff == sha_pkg::ST_ROUND);

      req_stall       = (state_ff != sha_pkg::ST_IDLE);
      rsp_valid       = (state_ff == sha_pkg::ST_OUT);
      rsp_digest_word = chain_ff[word_ff];
      rsp_word_index  = word_ff;
      rsp_last_word   = (word_ff == sha_pkg::WORD_LAST);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sha_pkg::ST_IDLE: begin
            if (accept) begin
               if (block_full) begin
                  state_in = sha_pkg::ST_ROUND;
               end else if (req_end_of_message) begin
                  state_in = sha_pkg::ST_PAD;
               end
            end
         end
         sha_pkg::ST_ROUND: begin
            if (round_ff == sha_pkg::ROUND_LAST) begin
               state_in = sha_pkg::ST_FOLD;
            end
         end
         sha_pkg::ST_FOLD: begin
            if (len_done_ff) begin
               state_in = sha_pkg::ST_OUT;
            end else if (mark_done_ff || eom_pend_ff) begin
               state_in = sha_pkg::ST_PAD;
            end else begin
               state_in = sha_pkg::ST_IDLE;
            end
         end
         sha_pkg::ST_PAD: begin
            if (block_full) begin
               state_in = sha_pkg::ST_ROUND;
            end
         end
         sha_pkg::ST_OUT: begin
            if (out_done) begin
               state_in = sha_pkg::ST_IDLE;
            end
         end
         default: state_in = sha_pkg::ST_IDLE;
      endcase
   end

   // datapath and flag next values
   always_comb begin
      count_in     = ctrl.shift_byte ? count_ff + 6'd1 : count_ff;
      total_in     = byte_take ? total_ff + 61'd1 : total_ff;
      round_in     = (state_ff == sha_pkg::ST_ROUND) ? round_ff + 6'd1 : '0;
      word_in      = out_take ? word_ff + 3'd1 : word_ff;
      chain_in     = chain_ff;
      mark_done_in = mark_done_ff || (state_ff == sha_pkg::ST_PAD);
      len_phase_in = len_phase_ff || ((state_ff == sha_pkg::ST_PAD) && is_len);
      len_done_in  = len_done_ff ||
                     ((state_ff == sha_pkg::ST_PAD) && is_len && block_full);
      eom_pend_in  = eom_pend_ff;

      if (accept) begin
         eom_pend_in = req_end_of_message && block_full;
      end
      if (state_ff == sha_pkg::ST_FOLD) begin
         eom_pend_in = 1'b0;
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = chain_ff[i] + vars[i];
         end
      end

      // digest delivered: back to a fresh message
      if (out_done) begin
         count_in     = '0;
         total_in     = '0;
         word_in      = '0;
         chain_in     = sha_pkg::IV;
         mark_done_in = 1'b0;
         len_phase_in = 1'b0;
         len_done_in  = 1'b0;
         eom_pend_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sha_pkg::ST_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         round_ff     <= '0;
         word_ff      <= '0;
         chain_ff     <= sha_pkg::IV;
         mark_done_ff <= 1'b0;
         len_phase_ff <= 1'b0;
         len_done_ff  <= 1'b0;
         eom_pend_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         round_ff     <= round_in;
         word_ff      <= word_in;
         chain_ff     <= chain_in;
         mark_done_ff <= mark_done_in;
         len_phase_ff <= len_phase_in;
         len_done_ff  <= len_done_in;
         eom_pend_ff  <= eom_pend_in;
      end
   end

endmodule

[design/sha_core.sv]
// SHA-256 round unit: block buffer / message schedule window and working vars.
// One round per step under control of the top-level sequencer. Uses sha_pkg.
module sha_core (
   input  logic                  clock,
   input  sha_pkg::core_ctrl_type ctrl,
   input  logic [5:0]            round_index,
   input  sha_pkg::hash_type     chain,
   output sha_pkg::hash_type     vars
);

   // word 0 of the window sits in the top 32 bits; bytes shift in at the bottom
   logic [511:0]      window_ff, window_in;
   sha_pkg::hash_type vars_ff, vars_in;

   sha_pkg::word_type w0, w1, w9, w14, w_next;
   sha_pkg::word_type t1, t2;
   sha_pkg::word_type va, vb, vc, vd, ve, vf, vg, vh;

   always_comb begin
      w0  = window_ff[511:480];
      w1  = window_ff[479:448];
      w9  = window_ff[223:192];
      w14 = window_ff[63:32];
      w_next = w0 + sha_pkg::small_sigma0(w1) + w9 + sha_pkg::small_sigma1(w14);

      va = vars_ff[0];
      vb = vars_ff[1];
      vc = vars_ff[2];
      vd = vars_ff[3];
      ve = vars_ff[4];
      vf = vars_ff[5];
      vg = vars_ff[6];
      vh = vars_ff[7];

      t1 = vh + sha_pkg::big_sigma1(ve) + ((ve & vf) ^ (~ve & vg))
           + sha_pkg::ROUND_K[round_index] + w0;
      t2 = sha_pkg::big_sigma0(va) + ((va & vb) ^ (va & vc) ^ (vb & vc));
   end

   always_comb begin
      window_in = window_ff;
      if (ctrl.shift_byte) begin
         window_in = {window_ff[503:0], ctrl.byte_value};
      end else if (ctrl.round_step) begin
         window_in = {window_ff[479:0], w_next};
      end
   end

   always_comb begin
      vars_in = vars_ff;
      if (ctrl.load_vars) begin
         vars_in = chain;
      end else if (ctrl.round_step) begin
         vars_in = {t1 + t2, va, vb, vc, vd + t1, ve, vf, vg};
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
      vars_ff   <= vars_in;
   end

   assign vars = vars_ff;

endmodule

[design/sha_checker.sv]
// Port-level checks for the SHA-256 hash engine, bound to the top level.
// Uses sha_pkg for the last word index.
module sha_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_digest_word,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_last_word
);

   // no new item while the digest is going out
   a_busy_on_output: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input not stalled during digest output");

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_digest_word) && $stable(rsp_word_index)))
      else $error("stalled digest word changed");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == sha_pkg::WORD_LAST)))
      else $error("last_word does not match word index");

   a_word_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_word) |=>
         (rsp_valid && (rsp_word_index == $past(rsp_word_index) + 3'd1)))
      else $error("digest words out of order");

   a_ready_after_digest: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_word) |=> (!rsp_valid && !req_stall))
      else $error("engine not ready after final digest word");

endmodule

bind sha256_hash_engine_top sha_checker u_sha_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_digest_word    (rsp_digest_word),
   .rsp_word_index     (rsp_word_index),
   .rsp_last_word      (rsp_last_word)
);
